[rtl/tsc_pkg.sv]
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants for the tab/space converter.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int MAX_TAB   = 64;
    localparam int TW_W      = 7;
    localparam int PHASE_W   = 6;
    localparam int CNT_W     = 7;
    localparam int CHAR_W    = 8;
    localparam int CFG_IDX_W = 8;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

    localparam logic [TW_W-1:0] TAB_WIDTH_RESET = 7'd8;
    localparam logic [TW_W-1:0] MAX_TAB_W       = TW_W'(MAX_TAB);

    localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 8'd1;

    typedef enum logic
    {
        MODE_DETAB = 1'b0,
        MODE_ENTAB = 1'b1
    } mode_t;

    typedef struct packed
    {
        logic [CNT_W-1:0]  nspaces;
        logic              has_char;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

[rtl/tsc_front.sv]
// ----------------------------------------------------------------------------
// tsc_front
// Accepts input bytes, tracks column and held spaces, issues emit commands.
// ----------------------------------------------------------------------------
module tsc_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tsc_pkg::CHAR_W-1:0]    in_char,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsc_pkg::TW_W-1:0]      cfg_data,
    input  tsc_pkg::q_stat_t              q_stat,
    output logic                          q_push,
    output tsc_pkg::cmd_t                 q_cmd
);
    import tsc_pkg::*;

    logic [TW_W-1:0]    tab_width_reg, tab_width_next;
    mode_t              mode_reg, mode_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PHASE_W-1:0] pending_reg, pending_next;

    logic [TW_W-1:0]    eff_w;
    logic [PHASE_W-1:0] phase_cur;
    logic [PHASE_W-1:0] phase_adv;
    logic [TW_W-1:0]    phase_inc;
    logic               accept;
    logic               cfg_wr;
    logic               emit;
    cmd_t               cmd;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;
    assign in_stall  = q_stat.full || cfg_valid;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        if (tab_width_reg == '0)
            eff_w = TW_W'(1);
        else if (tab_width_reg > MAX_TAB_W)
            eff_w = MAX_TAB_W;
        else
            eff_w = tab_width_reg;

        phase_cur = ({1'b0, phase_reg} >= eff_w) ? '0 : phase_reg;
        phase_inc = {1'b0, phase_cur} + TW_W'(1);
        phase_adv = (phase_inc >= eff_w) ? '0 : phase_inc[PHASE_W-1:0];
    end

    always_comb
    begin
        tab_width_next = tab_width_reg;
        mode_next      = mode_reg;
        phase_next     = phase_reg;
        pending_next   = pending_reg;
        emit           = 1'b0;
        cmd.nspaces    = '0;
        cmd.has_char   = 1'b0;
        cmd.ch         = in_char;

        if (cfg_wr)
        begin
            priority if (cfg_index == REG_TAB_WIDTH)
            begin
                tab_width_next = cfg_data;
                phase_next     = '0;
                pending_next   = '0;
            end
            else if (cfg_index == REG_MODE)
            begin
                mode_next    = mode_t'(cfg_data[0]);
                phase_next   = '0;
                pending_next = '0;
            end
            else
            begin
                tab_width_next = tab_width_reg;
            end
        end
        else if (accept)
        begin
            unique case (mode_reg)
                MODE_DETAB:
                begin
                    pending_next = '0;
                    emit         = 1'b1;
                    if (in_char == CH_TAB)
                    begin
                        cmd.nspaces = eff_w - {1'b0, phase_cur};
                        phase_next  = '0;
                    end
                    else
                    begin
                        cmd.has_char = 1'b1;
                        phase_next   = (in_char == CH_NEWLINE) ? '0 : phase_adv;
                    end
                end
                MODE_ENTAB:
                begin
                    if (in_char == CH_SPACE)
                    begin
                        phase_next = phase_adv;
                        if (phase_adv == '0)
                        begin
                            emit         = 1'b1;
                            cmd.has_char = 1'b1;
                            cmd.ch       = CH_TAB;
                            pending_next = '0;
                        end
                        else
                        begin
                            pending_next = pending_reg + PHASE_W'(1);
                        end
                    end
                    else if (in_char == CH_TAB)
                    begin
                        emit         = 1'b1;
                        cmd.has_char = 1'b1;
                        pending_next = '0;
                        phase_next   = '0;
                    end
                    else
                    begin
                        emit         = 1'b1;
                        cmd.nspaces  = {1'b0, pending_reg};
                        cmd.has_char = 1'b1;
                        pending_next = '0;
                        phase_next   = (in_char == CH_NEWLINE) ? '0 : phase_adv;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    assign q_push = emit;
    assign q_cmd  = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_width_reg <= TAB_WIDTH_RESET;
            mode_reg      <= MODE_DETAB;
            phase_reg     <= '0;
            pending_reg   <= '0;
        end
        else
        begin
            tab_width_reg <= tab_width_next;
            mode_reg      <= mode_next;
            phase_reg     <= phase_next;
            pending_reg   <= pending_next;
        end
    end

endmodule

[rtl/tsc_queue.sv]
// ----------------------------------------------------------------------------
// tsc_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module tsc_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tsc_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output tsc_pkg::cmd_t    head_cmd,
    output tsc_pkg::q_stat_t stat
);
    import tsc_pkg::*;

    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/tsc_back.sv]
// ----------------------------------------------------------------------------
// tsc_back
// Plays out commands as output bytes through a registered output stage.
// ----------------------------------------------------------------------------
module tsc_back
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  tsc_pkg::q_stat_t           q_stat,
    input  tsc_pkg::cmd_t              head_cmd,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [tsc_pkg::CHAR_W-1:0] out_char,
    output logic                       last
);
    import tsc_pkg::*;

    logic              act_valid_reg, act_valid_next;
    cmd_t              act_reg, act_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              last_reg, last_next;

    logic advance;
    logic emit;
    logic final_byte;

    always_comb
    begin
        advance        = !out_valid_reg || !out_stall;
        emit           = advance && act_valid_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        act_next       = act_reg;
        act_valid_next = act_valid_reg;
        final_byte     = 1'b0;

        if (advance)
            out_valid_next = 1'b0;

        if (emit)
        begin
            out_valid_next = 1'b1;
            if (act_reg.nspaces != '0)
            begin
                out_char_next       = CH_SPACE;
                final_byte          = (act_reg.nspaces == CNT_W'(1)) && !act_reg.has_char;
                act_next.nspaces    = act_reg.nspaces - CNT_W'(1);
            end
            else
            begin
                out_char_next = act_reg.ch;
                final_byte    = 1'b1;
            end
            last_next = final_byte;
            if (final_byte)
                act_valid_next = 1'b0;
        end

        q_pop = !q_stat.empty && (!act_valid_reg || (emit && final_byte));
        if (q_pop)
        begin
            act_next       = head_cmd;
            act_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_valid_reg <= act_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/tab_space_converter.sv]
// ----------------------------------------------------------------------------
// tab_space_converter
// Tab expansion and space compression on a byte stream.
// ----------------------------------------------------------------------------
// The first output byte passes the command queue, the back part's active-command
// register and its output register. The output carries one byte per cycle while
// out_stall is low; an input item of k results is played out byte by byte through the
// back part's single output register. Items that cause no result push no command;
// a two-entry command queue decouples input from output. Reset clears column,
// held spaces and queue, loads tab width 8 and detab mode.
// ----------------------------------------------------------------------------
module tab_space_converter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tsc_pkg::CHAR_W-1:0]    in_char,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tsc_pkg::CHAR_W-1:0]    out_char,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsc_pkg::TW_W-1:0]      cfg_data
);
    import tsc_pkg::*;

    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;
    cmd_t    q_cmd;
    cmd_t    head_cmd;

    tsc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_char   (in_char),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    tsc_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    tsc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .head_cmd  (head_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last      (last)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command popped from empty queue");

    a_cmd_sane: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_cmd.nspaces <= CNT_W'(MAX_TAB))
                   && ((q_cmd.nspaces != '0) || q_cmd.has_char))
        else $error("malformed emit command");
`endif

endmodule

[verif/tab_space_converter_test.sv]
// ----------------------------------------------------------------------------
// tab_space_converter_test
// Streams text bytes through the converter in detab and entab mode over a
// range of tab widths. Every accepted byte updates a local column/held-space
// model, and each output byte and its last flag are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tab_space_converter_test;

    import tsc_pkg::*;

    localparam int CLOCK_LIMIT = 2_000_000;
    localparam int LONG_HOLD   = 400;

    typedef struct packed
    {
        logic [CHAR_W-1:0] ch;
        logic              lst;
    } out_byte_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [CHAR_W-1:0]    in_char   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CHAR_W-1:0]    out_char;
    logic                 last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TW_W-1:0]      cfg_data  = '0;

    logic [TW_W-1:0]    tab_stop_reg = TAB_WIDTH_RESET;
    mode_t              conv_mode    = MODE_DETAB;
    logic [PHASE_W-1:0] col_phase    = '0;
    logic [PHASE_W-1:0] held_spaces  = '0;

    logic [CHAR_W-1:0] source_text[$];
    out_byte_t         converted_bytes[$];
    out_byte_t         want_byte;

    int idle_pct      = 0;
    int tx_gap        = 0;
    int rx_gap        = 0;
    int rx_hold_req   = 0;
    int rx_hold_seen  = 0;
    int rx_hold_left  = 0;
    int fail_cnt      = 0;
    int sent_cnt      = 0;
    int checked_cnt   = 0;
    int reg_write_cnt = 0;
    int cycle_cnt     = 0;

    tab_space_converter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_char   (in_char),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [TW_W-1:0] stop_width(input logic [TW_W-1:0] raw);
        if (raw == '0)
            return TW_W'(1);
        if (raw > MAX_TAB_W)
            return MAX_TAB_W;
        return raw;
    endfunction

    function automatic logic [PHASE_W-1:0] next_col(input logic [PHASE_W-1:0] p,
                                                     input logic [TW_W-1:0] w);
        logic [TW_W-1:0] n;
        n = TW_W'(p) + 1'b1;
        return (n >= w) ? '0 : n[PHASE_W-1:0];
    endfunction

    function automatic void convert_char(input logic [CHAR_W-1:0] c);
        logic [TW_W-1:0]   w;
        logic [CHAR_W-1:0] bytes[$];
        int                k;
        w = stop_width(tab_stop_reg);
        if (TW_W'(col_phase) >= w)
            col_phase = '0;
        if (conv_mode == MODE_DETAB)
        begin
            if (c == CH_TAB)
            begin
                for (k = 0; k < int'(w - TW_W'(col_phase)); k++)
                    bytes.push_back(CH_SPACE);
                col_phase = '0;
            end
            else
            begin
                bytes.push_back(c);
                col_phase = (c == CH_NEWLINE) ? '0 : next_col(col_phase, w);
            end
            held_spaces = '0;
        end
        else if (c == CH_SPACE)
        begin
            held_spaces = held_spaces + 1'b1;
            col_phase   = next_col(col_phase, w);
            if (col_phase == '0)
            begin
                bytes.push_back(CH_TAB);
                held_spaces = '0;
            end
        end
        else if (c == CH_TAB)
        begin
            held_spaces = '0;
            bytes.push_back(CH_TAB);
            col_phase = '0;
        end
        else
        begin
            for (k = 0; k < int'(held_spaces); k++)
                bytes.push_back(CH_SPACE);
            held_spaces = '0;
            bytes.push_back(c);
            col_phase = (c == CH_NEWLINE) ? '0 : next_col(col_phase, w);
        end
        for (k = 0; k < bytes.size(); k++)
            converted_bytes.push_back('{ch: bytes[k], lst: (k == bytes.size() - 1)});
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [TW_W-1:0] val);
        if (idx == REG_TAB_WIDTH)
            tab_stop_reg = val;
        else if (idx == REG_MODE)
            conv_mode = mode_t'(val[0]);
        else
            return;
        col_phase   = '0;
        held_spaces = '0;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TW_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, val);
        reg_write_cnt++;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (source_text.size() != 0 || in_valid || converted_bytes.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic add_text(input int n);
        int              k;
        int              r;
        int              run;
        logic [TW_W-1:0] w;
        w = stop_width(tab_stop_reg);
        k = 0;
        while (k < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                run = $urandom_range(1, int'(w) + 1);
                if (run > n - k)
                    run = n - k;
                repeat (run) source_text.push_back(CH_SPACE);
                k += run;
            end
            else
            begin
                if (r < 35)
                    source_text.push_back(CH_TAB);
                else if (r < 43)
                    source_text.push_back(CH_NEWLINE);
                else if (r < 90)
                    source_text.push_back(CHAR_W'($urandom_range(8'h21, 8'h7E)));
                else
                    source_text.push_back(CHAR_W'($urandom_range(0, 255)));
                k++;
            end
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_char  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                convert_char(in_char);
                sent_cnt++;
            end
            if (!in_valid || !in_stall)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (source_text.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_char  <= source_text.pop_front();
                    if ($urandom_range(0, 99) < idle_pct)
                        tx_gap = $urandom_range(1, 17);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (converted_bytes.size() == 0)
                begin
                    $error("out_char: no byte expected, got %h", out_char);
                    fail_cnt++;
                end
                else
                begin
                    want_byte = converted_bytes.pop_front();
                    if (out_char !== want_byte.ch)
                    begin
                        $error("out_char: expected %h, got %h", want_byte.ch, out_char);
                        fail_cnt++;
                    end
                    if (last !== want_byte.lst)
                    begin
                        $error("last: expected %b, got %b", want_byte.lst, last);
                        fail_cnt++;
                    end
                end
                checked_cnt++;
            end
            if (rx_hold_req != rx_hold_seen)
            begin
                rx_hold_seen = rx_hold_req;
                rx_hold_left = LONG_HOLD;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                rx_gap = $urandom_range(0, 16);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CLOCK_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int ph;
        int r;
        int w_pick;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: detab, width 8
        source_text.push_back("x");
        source_text.push_back(CH_TAB);
        source_text.push_back(8'h00);
        source_text.push_back(8'hFF);
        source_text.push_back(CH_NEWLINE);
        source_text.push_back(CH_TAB);
        wait_idle();

        // width zero acts as one: every space becomes a tab
        write_reg(REG_TAB_WIDTH, 7'd0);
        write_reg(REG_MODE, TW_W'(MODE_ENTAB));
        source_text.push_back(CH_SPACE);
        source_text.push_back("a");
        wait_idle();

        // width above the maximum: flush on a letter and on newline, drop on tab
        write_reg(REG_TAB_WIDTH, 7'd100);
        repeat (3) source_text.push_back(CH_SPACE);
        source_text.push_back("z");
        source_text.push_back(CH_SPACE);
        source_text.push_back(CH_TAB);
        source_text.push_back(CH_SPACE);
        source_text.push_back(CH_NEWLINE);
        wait_idle();

        // unknown index keeps held spaces, a real write drops them
        write_reg(REG_TAB_WIDTH, 7'd4);
        repeat (2) source_text.push_back(CH_SPACE);
        wait_idle();
        write_reg(CFG_IDX_W'(200), 7'd3);
        repeat (4) source_text.push_back(CH_SPACE);
        wait_idle();
        write_reg(REG_MODE, TW_W'(MODE_ENTAB));
        source_text.push_back("k");
        wait_idle();

        // widest expansion
        write_reg(REG_MODE, TW_W'(MODE_DETAB));
        write_reg(REG_TAB_WIDTH, MAX_TAB_W);
        source_text.push_back(CH_TAB);
        source_text.push_back("m");
        source_text.push_back(CH_TAB);
        wait_idle();

        for (ph = 0; ph < 10; ph++)
        begin
            r = $urandom_range(0, 2);
            idle_pct = (ph >= 8) ? 0 : (r == 0) ? 0 : (r == 1) ? 10 : 35;
            case (ph)
                0: w_pick = 1;
                1: w_pick = MAX_TAB;
                2: w_pick = 127;
                3: w_pick = 0;
                default:
                begin
                    r = $urandom_range(0, 99);
                    w_pick = (r < 60) ? $urandom_range(1, 16) :
                             (r < 80) ? $urandom_range(17, MAX_TAB) : $urandom_range(0, 127);
                end
            endcase
            if (ph < 4 || $urandom_range(0, 1) == 1)
                write_reg(REG_TAB_WIDTH, TW_W'(w_pick));
            write_reg(REG_MODE, TW_W'($urandom_range(0, 127)));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(2, 255)), TW_W'($urandom_range(0, 127)));
            if (ph == 2)
                rx_hold_req++;
            add_text(20);
            // hold off the sender until the output side has drained
            if (ph == 5)
                wait_idle();
            add_text(20);
            wait_idle();
        end

        wait_idle();
        repeat (16) @(negedge clk);
        if (converted_bytes.size() != 0)
        begin
            $error("out_char: %0d expected bytes never arrived", converted_bytes.size());
            fail_cnt++;
        end

        $display("Run: %0d text requests, %0d output bytes checked, %0d register writes.",
                 sent_cnt, checked_cnt, reg_write_cnt);
        $display("Both modes, widths 0 to 127, a long output hold and a drain pause.");
        if (fail_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/tsc_pkg.sv
rtl/tsc_front.sv
rtl/tsc_queue.sv
rtl/tsc_back.sv
rtl/tab_space_converter.sv
verif/tab_space_converter_test.sv
